FILE: sv/dosod_pkg.sv
// Shared types, constants and the arctangent table for the dual-sensor odometry core.
// No dependencies; imported by the core and its checker.
`default_nettype none
package dosod_pkg;

  localparam int CORDIC_ITERATIONS = 24;
  localparam logic [4:0] ITER_LAST = 5'(CORDIC_ITERATIONS - 1);

  localparam logic [19:0] BASELINE_RESET = 20'd6299;
  localparam logic [31:0] MPC_RESET      = 32'd136365;
  localparam logic [31:0] INV_GAIN_Q30   = 32'd652032874;
  localparam logic [31:0] US_PER_SEC     = 32'd1000000;
  localparam logic [31:0] QUARTER_TURN   = 32'h4000_0000;

  // register map, byte addresses
  localparam logic [2:0] ADDR_BASELINE = 3'd0;
  localparam logic [2:0] ADDR_MPC      = 3'd4;

  typedef struct packed {
    logic signed [15:0] left_rel_x;
    logic signed [15:0] left_rel_y;
    logic signed [15:0] right_rel_x;
    logic signed [15:0] right_rel_y;
    logic [19:0]        elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               vel_valid;
  } out_item_t;

  // atan(2^-i) in binary-angle units, rounded to nearest
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/dual_optical_sensor_odometry_core.sv
// Dead-reckoning odometry core for two optical motion sensors, with APB register port.
// Depends on dosod_pkg.
`default_nettype none

// One input transaction carries the raw counts of both sensors and the time since
// the last tick; one output transaction returns position, heading and velocity.
// Work is done one tick at a time by a small sequencer around a shared CORDIC
// iteration unit (used first in vectoring mode for the heading increment, then in
// rotation mode for the step), a 40x8 multiply-accumulate unit (six products per
// tick, each with load, run and store states) and a restoring divider that retires
// one quotient bit a cycle, one axis after the other. A tick skips the heading
// CORDIC when the heading needs none (equal x counts or zero baseline) and skips the
// divider when elapsed_us is zero; the divider dominates the time per tick.
// in_ready is high only while the sequencer is idle, but a finished result sits
// in the output register, so the next tick may start while it waits to be taken.
// A tick that finishes while the previous result is still waiting holds until it goes.
// Registers: 0x0 baseline_counts (20 bit), 0x4 meters_per_count (32 bit);
// write them only while the core is idle. No clearing pass after reset.
module dual_optical_sensor_odometry_core
  import dosod_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  // output channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  // APB
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_HEAD, S_HAPPLY, S_RINIT, S_ROT, S_MLOAD, S_MRUN, S_MSTORE,
    S_ACC, S_DLOAD, S_DRUN, S_DSTORE, S_DONE
  } state_t;

  // product sequence
  localparam logic [2:0] OP_GAIN_X = 3'd0;
  localparam logic [2:0] OP_GAIN_Y = 3'd1;
  localparam logic [2:0] OP_STEP_X = 3'd2;
  localparam logic [2:0] OP_STEP_Y = 3'd3;
  localparam logic [2:0] OP_VEL_X  = 3'd4;
  localparam logic [2:0] OP_VEL_Y  = 3'd5;

  state_t state;

  // configuration
  logic [19:0] baseline;
  logic [31:0] mpc;

  // persistent odometry state
  logic [31:0]        heading_angle;
  logic signed [63:0] pos_x_acc, pos_y_acc;

  // per-tick working registers
  logic signed [39:0] sum_x, sum_y;   // vector sum, counts Q14
  logic               dneg, dzero;
  logic [19:0]        us;
  logic signed [39:0] cx, cy;
  logic [31:0]        cz;
  logic               vect;
  logic [4:0]         iter;
  logic signed [39:0] gx, gy;         // rotated, gain removed
  logic signed [63:0] step_x, step_y; // metres Q32.32
  logic signed [63:0] num_x, num_y;   // velocity numerators
  logic [2:0]         op;
  logic [39:0]        mul_a;
  logic [31:0]        mul_b;
  logic               mul_neg;
  logic [71:0]        mul_acc;
  logic [1:0]         mul_cnt;
  logic [57:0]        div_q;
  logic [20:0]        div_rem;
  logic [5:0]         div_cnt;
  logic               div_neg;
  logic               dax;            // divider axis: 0 x, 1 y
  logic signed [31:0] vel_x, vel_y;

  // ---------------- input remap: x = -rel_y, y = -rel_x ----------------
  logic signed [17:0] d_in, sx_in, sy_in;
  logic [17:0]        dmag_in;
  always_comb begin
    // rx - lx = left_rel_y - right_rel_y
    d_in  = 18'(in_data.left_rel_y) - 18'(in_data.right_rel_y);
    sx_in = -(18'(in_data.left_rel_y) + 18'(in_data.right_rel_y));
    sy_in = -(18'(in_data.left_rel_x) + 18'(in_data.right_rel_x));
    dmag_in = d_in[17] ? 18'(-d_in) : d_in;
  end

  // ---------------- shared CORDIC iteration ----------------
  // vectoring drives y to zero, rotation drives z to zero; same datapath
  logic signed [39:0] xsh, ysh, nx, ny;
  logic [31:0]        at, nz;
  logic               plus;
  always_comb begin
    xsh  = cx >>> iter;
    ysh  = cy >>> iter;
    at   = atan_lut(iter);
    plus = vect ? ~cy[39] : cz[31];
    nx   = plus ? cx + ysh : cx - ysh;
    ny   = plus ? cy - xsh : cy + xsh;
    nz   = plus ? cz + at  : cz - at;
  end

  // ---------------- multiply-accumulate unit ----------------
  logic [7:0]         mul_chunk;
  logic [47:0]        mul_part;
  logic [71:0]        mul_next;
  logic signed [72:0] mul_prod, p30, p15;
  logic signed [39:0] mul_v;
  logic [31:0]        mul_bsel;
  logic signed [63:0] sxs16, sys16;
  always_comb begin
    mul_chunk = mul_b[{mul_cnt, 3'b000} +: 8];
    mul_part  = mul_a * {40'd0, mul_chunk};
    mul_next  = mul_acc + ({24'd0, mul_part} << {mul_cnt, 3'b000});
    mul_prod  = mul_neg ? -$signed({1'b0, mul_acc}) : $signed({1'b0, mul_acc});
    p30 = mul_prod >>> 30;
    p15 = mul_prod >>> 15;
    sxs16 = step_x >>> 16;
    sys16 = step_y >>> 16;
    case (op)
      OP_GAIN_X: begin mul_v = cx;           mul_bsel = INV_GAIN_Q30; end
      OP_GAIN_Y: begin mul_v = cy;           mul_bsel = INV_GAIN_Q30; end
      OP_STEP_X: begin mul_v = gx;           mul_bsel = mpc;          end
      OP_STEP_Y: begin mul_v = gy;           mul_bsel = mpc;          end
      OP_VEL_X:  begin mul_v = sxs16[39:0];  mul_bsel = US_PER_SEC;   end
      OP_VEL_Y:  begin mul_v = sys16[39:0];  mul_bsel = US_PER_SEC;   end
      default:   begin mul_v = '0;           mul_bsel = '0;           end
    endcase
  end

  // ---------------- restoring divider step ----------------
  logic [21:0]        div_t;
  logic               div_ge;
  logic [21:0]        div_sub;
  logic signed [63:0] div_n;
  always_comb begin
    div_t   = {div_rem, div_q[57]};
    div_sub = div_t - {2'b00, us};
    div_ge  = div_t >= {2'b00, us};
    div_n   = dax ? num_y : num_x;
  end

  // ---------------- helpers ----------------
  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v[63:31] == '0 || v[63:31] == '1) return v[31:0];
    return v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  function automatic logic [31:0] sat_mag(input logic [57:0] q, input logic neg);
    logic [57:0] nq;
    nq = -q;
    if (neg) return (q > 58'h8000_0000) ? 32'h8000_0000 : nq[31:0];
    return (q > 58'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  logic [31:0]        h_delta;
  logic signed [63:0] px16, py16;
  always_comb begin
    if (dzero)              h_delta = '0;
    else if (baseline == '0) h_delta = QUARTER_TURN;
    else                    h_delta = cz;
    px16 = pos_x_acc >>> 16;
    py16 = pos_y_acc >>> 16;
  end

  // ---------------- APB ----------------
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? mpc : {12'd0, baseline};
  assign in_ready = (state == S_IDLE);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      baseline      <= BASELINE_RESET;
      mpc           <= MPC_RESET;
      heading_angle <= '0;
      pos_x_acc     <= '0;
      pos_y_acc     <= '0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == ADDR_MPC[2]) mpc <= pwdata;
        else                         baseline <= pwdata[19:0];
      end
      // S_DONE reloads the output register itself
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            sum_x <= {{8{sx_in[17]}}, sx_in, 14'd0};
            sum_y <= {{8{sy_in[17]}}, sy_in, 14'd0};
            dneg  <= d_in[17];
            dzero <= (d_in == '0);
            us    <= in_data.elapsed_us;
            cx    <= {8'd0, baseline, 12'd0};
            cy    <= {10'd0, dmag_in, 12'd0};
            cz    <= '0;
            vect  <= 1'b1;
            iter  <= '0;
            state <= (d_in == '0 || baseline == '0) ? S_HAPPLY : S_HEAD;
          end
        end
        S_HEAD, S_ROT: begin
          cx   <= nx;
          cy   <= ny;
          cz   <= nz;
          iter <= iter + 5'd1;
          if (iter == ITER_LAST) begin
            op    <= OP_GAIN_X;
            state <= (state == S_HEAD) ? S_HAPPLY : S_MLOAD;
          end
        end
        S_HAPPLY: begin
          heading_angle <= heading_angle + (dneg ? -h_delta : h_delta);
          state <= S_RINIT;
        end
        S_RINIT: begin
          // exact quarter turns first, residual angle goes to the CORDIC
          case (heading_angle[31:30])
            2'd1:    begin cx <= -sum_y; cy <= sum_x;  end
            2'd2:    begin cx <= -sum_x; cy <= -sum_y; end
            2'd3:    begin cx <= sum_y;  cy <= -sum_x; end
            default: begin cx <= sum_x;  cy <= sum_y;  end
          endcase
          cz    <= {2'b00, heading_angle[29:0]};
          vect  <= 1'b0;
          iter  <= '0;
          state <= S_ROT;
        end
        S_MLOAD: begin
          mul_a   <= mul_v[39] ? 40'(-mul_v) : mul_v;
          mul_neg <= mul_v[39];
          mul_b   <= mul_bsel;
          mul_acc <= '0;
          mul_cnt <= '0;
          state   <= S_MRUN;
        end
        S_MRUN: begin
          mul_acc <= mul_next;
          mul_cnt <= mul_cnt + 2'd1;
          if (mul_cnt == 2'd3) state <= S_MSTORE;
        end
        S_MSTORE: begin
          case (op)
            OP_GAIN_X: gx <= p30[39:0];
            OP_GAIN_Y: gy <= p30[39:0];
            OP_STEP_X: step_x <= p15[63:0];
            OP_STEP_Y: step_y <= p15[63:0];
            OP_VEL_X:  num_x <= mul_prod[63:0];
            OP_VEL_Y:  num_y <= mul_prod[63:0];
            default: ;
          endcase
          op    <= op + 3'd1;
          state <= (op == OP_VEL_Y) ? S_ACC : S_MLOAD;
        end
        S_ACC: begin
          pos_x_acc <= sat_add64(pos_x_acc, step_x);
          pos_y_acc <= sat_add64(pos_y_acc, step_y);
          dax <= 1'b0;
          if (us == '0) begin
            vel_x <= '0;
            vel_y <= '0;
            state <= S_DONE;
          end else begin
            state <= S_DLOAD;
          end
        end
        S_DLOAD: begin
          div_neg <= div_n[63];
          div_q   <= div_n[63] ? 58'(-div_n) : div_n[57:0];
          div_rem <= '0;
          div_cnt <= '0;
          state   <= S_DRUN;
        end
        S_DRUN: begin
          div_rem <= div_ge ? div_sub[20:0] : div_t[20:0];
          div_q   <= {div_q[56:0], div_ge};
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'd57) state <= S_DSTORE;
        end
        S_DSTORE: begin
          if (dax) begin
            vel_y <= sat_mag(div_q, div_neg);
            state <= S_DONE;
          end else begin
            vel_x <= sat_mag(div_q, div_neg);
            dax   <= 1'b1;
            state <= S_DLOAD;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid          <= 1'b1;
            out_data.pos_x     <= sat32(px16);
            out_data.pos_y     <= sat32(py16);
            out_data.heading   <= heading_angle;
            out_data.vel_x     <= vel_x;
            out_data.vel_y     <= vel_y;
            out_data.vel_valid <= (us != '0);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/dosod_chk.sv
// Port-level checker for the odometry core, bound to the top level.
// Depends on dosod_pkg and dual_optical_sensor_odometry_core.
`default_nettype none
module dosod_chk
  import dosod_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire out_item_t   out_data,
  input wire logic        pready
);

  // a transaction occupies the sequencer for many cycles
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an input transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("output transaction dropped or changed while stalled");

  a_vel_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.vel_valid) |-> (out_data.vel_x == '0 && out_data.vel_y == '0))
    else $error("velocity nonzero with vel_valid low");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("core not idle after reset");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind dual_optical_sensor_odometry_core dosod_chk u_dosod_chk (.*);
`default_nettype wire
